// File: hdl/cpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpw_pkg;

    // Field and datapath widths.
    localparam int IDX_W      = 20;  // cell index
    localparam int GW_W       = 13;  // grid width, column
    localparam int CS_W       = 12;  // cell size
    localparam int OFF_W      = 24;  // car offsets
    localparam int HD_W       = 16;  // heading
    localparam int LIM_W      = 23;  // distance limits
    localparam int MID_W      = LIM_W + 1;
    localparam int ROW_W      = IDX_W + 1;
    localparam int X_W        = CS_W + GW_W + 2;
    localparam int Y_W        = CS_W + ROW_W + 2;
    localparam int XY_W       = 24;  // in-range coordinate, |v| < 2^23
    localparam int SQ_W       = 2 * LIM_W;
    localparam int D2_W       = 48;
    localparam int ROOT_W     = D2_W / 2;
    localparam int SREM_W     = ROOT_W + 2;
    localparam int CW         = 34;  // CORDIC vector width
    localparam int ZW         = 18;  // angle width
    localparam int CORDIC_STEPS = 15;
    localparam int WT_W       = 7;
    localparam int NUM_W      = 19;
    localparam int QDIV_STEPS = 7;
    localparam int QS_W       = ROOT_W + QDIV_STEPS - 1;
    localparam int CFG_W      = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [NUM_W-1:0]  FALLOFF_NUM  = 19'd409600;
    // 409600 / q reaches 128 exactly when q is at most 3200.
    localparam logic [ROOT_W-1:0] SAT_Q        = 24'd3200;
    localparam logic [WT_W-1:0]   NEAR_WEIGHT  = 7'd100;
    localparam logic [WT_W-1:0]   WEIGHT_MAX   = 7'd127;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 18'sd16384;
    localparam logic signed [ZW-1:0] HALF_TURN    = 18'sd32768;

    localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        18'd8192, 18'd4836, 18'd2555, 18'd1297, 18'd651, 18'd326, 18'd163, 18'd81,
        18'd41, 18'd20, 18'd10, 18'd5, 18'd3, 18'd1, 18'd1
    };

    // Where the bearing comes from.
    typedef enum logic [2:0] {
        QD_CORDIC,
        QD_UP,
        QD_DOWN,
        QD_NEG_UP,
        QD_NEG_DOWN,
        QD_NEG_AXIS
    } t_quad;

    typedef enum logic [CFG_W-1:0] {
        CFG_GRID_WIDTH,
        CFG_CELL_SIZE,
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_HEADING,
        CFG_NEAR,
        CFG_IDEAL,
        CFG_FAR
    } t_cfg_reg;

    typedef struct packed {
        logic  valid;
        logic  last;
        logic  kill;
        logic  nearband;
        logic  sat;
        logic  atten;
        t_quad quad;
    } t_side;

endpackage

`default_nettype wire

// File: hdl/cpw_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One restoring division step by the grid width, and one by the stride.
module cpw_div_cell #(
    parameter int STRIDE = 1,
    parameter int SW     = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [cpw_pkg::GW_W-1:0]    i_width,
    input  cpw_pkg::t_side              i_side,
    input  logic [cpw_pkg::GW_W-1:0]    i_rem,
    input  logic [cpw_pkg::IDX_W-1:0]   i_num,
    input  logic [SW-1:0]               i_srem,
    output cpw_pkg::t_side              o_side,
    output logic [cpw_pkg::GW_W-1:0]    o_rem,
    output logic [cpw_pkg::IDX_W-1:0]   o_num,
    output logic [SW-1:0]               o_srem
);
    import cpw_pkg::*;

    logic [GW_W:0] w_trial;
    logic          w_take;
    logic [SW:0]   w_strial;
    logic          w_stake;
    t_side               r_side;
    logic [GW_W-1:0]     r_rem;
    logic [IDX_W-1:0]    r_num;
    logic [SW-1:0]       r_srem;

    assign w_trial  = {i_rem, i_num[IDX_W-1]};
    assign w_take   = w_trial >= {1'b0, i_width};
    assign w_strial = {i_srem, i_num[IDX_W-1]};
    assign w_stake  = w_strial >= (SW+1)'(STRIDE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= GW_W'(w_take ? w_trial - {1'b0, i_width} : w_trial);
            r_num  <= {i_num[IDX_W-2:0], w_take};
            r_srem <= SW'(w_stake ? w_strial - (SW+1)'(STRIDE) : w_strial);
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_srem = r_srem;

endmodule

`default_nettype wire

// File: hdl/cpw_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One root bit of a restoring integer square root.
module cpw_sqrt_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  cpw_pkg::t_side               i_side,
    input  logic [cpw_pkg::SREM_W-1:0]   i_rem,
    input  logic [cpw_pkg::ROOT_W-1:0]   i_root,
    input  logic [cpw_pkg::D2_W-1:0]     i_num,
    output cpw_pkg::t_side               o_side,
    output logic [cpw_pkg::SREM_W-1:0]   o_rem,
    output logic [cpw_pkg::ROOT_W-1:0]   o_root,
    output logic [cpw_pkg::D2_W-1:0]     o_num
);
    import cpw_pkg::*;

    logic [SREM_W+1:0] w_trial;
    logic [SREM_W+1:0] w_test;
    logic              w_take;
    t_side             r_side;
    logic [SREM_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [D2_W-1:0]   r_num;

    assign w_trial = {i_rem, i_num[D2_W-1 -: 2]};
    assign w_test  = {2'b00, i_root, 2'b01};
    assign w_take  = w_trial >= w_test;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= SREM_W'(w_take ? w_trial - w_test : w_trial);
            r_root <= {i_root[ROOT_W-2:0], w_take};
            r_num  <= {i_num[D2_W-3:0], 2'b00};
        end
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_num  = r_num;

endmodule

`default_nettype wire

// File: hdl/cpw_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One vectoring rotation; the shifts round toward minus infinity.
module cpw_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [cpw_pkg::CW-1:0]    i_cx,
    input  logic signed [cpw_pkg::CW-1:0]    i_cy,
    input  logic signed [cpw_pkg::ZW-1:0]    i_z,
    output logic signed [cpw_pkg::CW-1:0]    o_cx,
    output logic signed [cpw_pkg::CW-1:0]    o_cy,
    output logic signed [cpw_pkg::ZW-1:0]    o_z
);
    import cpw_pkg::*;

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [ZW-1:0] w_atan;
    logic                 w_up;
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [ZW-1:0] r_z;

    assign w_dx   = i_cy >>> STEP;
    assign w_dy   = i_cx >>> STEP;
    assign w_atan = $signed(ATAN_TAB[STEP]);
    assign w_up   = !i_cy[CW-1] && (i_cy != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_up) begin
                r_cx <= i_cx + w_dx;
                r_cy <= i_cy - w_dy;
                r_z  <= i_z + w_atan;
            end else begin
                r_cx <= i_cx - w_dx;
                r_cy <= i_cy + w_dy;
                r_z  <= i_z - w_atan;
            end
        end
    end

    assign o_cx = r_cx;
    assign o_cy = r_cy;
    assign o_z  = r_z;

endmodule

`default_nettype wire

// File: hdl/cpw_recip_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One quotient bit of the falloff constant divided by the band offset.
module cpw_recip_cell #(
    parameter int BIT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  cpw_pkg::t_side              i_side,
    input  logic [cpw_pkg::ROOT_W-1:0]  i_q,
    input  logic [cpw_pkg::NUM_W-1:0]   i_rem,
    input  logic [cpw_pkg::WT_W-1:0]    i_quo,
    output cpw_pkg::t_side              o_side,
    output logic [cpw_pkg::ROOT_W-1:0]  o_q,
    output logic [cpw_pkg::NUM_W-1:0]   o_rem,
    output logic [cpw_pkg::WT_W-1:0]    o_quo
);
    import cpw_pkg::*;

    logic [QS_W-1:0]   w_sub;
    logic              w_take;
    t_side             r_side;
    logic [ROOT_W-1:0] r_q;
    logic [NUM_W-1:0]  r_rem;
    logic [WT_W-1:0]   r_quo;

    assign w_sub  = QS_W'(i_q) << BIT;
    assign w_take = QS_W'(i_rem) >= w_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q   <= i_q;
            r_rem <= w_take ? NUM_W'(QS_W'(i_rem) - w_sub) : i_rem;
            r_quo <= {i_quo[WT_W-2:0], w_take};
        end
    end

    assign o_side = r_side;
    assign o_q    = r_q;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: hdl/cell_proximity_heading_weight.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake                      Payload
// s_axis     in         i_s_axis_tvalid/o_s_axis_tready  tdata: cell_index; tlast: final_cell
// m_axis     out        o_m_axis_tvalid/i_m_axis_tready  tdata: cell_weight; tlast: final_weight
// cfg        in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// One beat is taken every cycle while the chain is not frozen by a stalled output.
// Each beat passes through 20 division cells, 6 coordinate stages, 24 square-root
// cells (the 15 CORDIC cells run beside them), one stage and 7 cells of falloff
// division, and the output register.
// Reset is synchronous and active low; it clears all valid flags and loads the
// register defaults. A stalled output freezes the chain only when its last cell
// holds a result, so empty slots drain toward the output.
module cell_proximity_heading_weight #(
    parameter int STRIDE     = 1,
    parameter int BERTH      = 16384,
    parameter int ATTENUATOR = 2,
    parameter int MAX_CELLS  = 1048576
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [23:0]                       i_s_axis_tdata,  // [19:0] cell_index
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // [6:0] cell_weight
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cpw_pkg::CFG_W-1:0]         i_cfg_index,
    input  logic [cpw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cpw_pkg::*;

    localparam int SW         = (STRIDE > 1) ? $clog2(STRIDE) : 1;
    localparam int DIV_CELLS  = IDX_W;
    localparam int SQRT_CELLS = ROOT_W;
    localparam int ZDELAY     = SQRT_CELLS - CORDIC_STEPS;

    // Configuration registers and derived squares.
    logic [GW_W-1:0]          r_grid_width;
    logic [CS_W-1:0]          r_cell_size;
    logic signed [OFF_W-1:0]  r_offset_x;
    logic signed [OFF_W-1:0]  r_offset_y;
    logic signed [HD_W-1:0]   r_heading;
    logic [LIM_W-1:0]         r_near;
    logic [LIM_W-1:0]         r_ideal;
    logic [LIM_W-1:0]         r_far;
    logic [D2_W-1:0]          r_near_sq;
    logic [D2_W-1:0]          r_far_sq;
    logic [D2_W-1:0]          r_mid_sq;
    logic [MID_W-1:0]         n_mid;
    logic [GW_W-1:0]          w_width;

    logic w_en;
    logic w_accept;

    // Division chain.
    t_side              w_dside [DIV_CELLS+1];
    logic [GW_W-1:0]    w_drem  [DIV_CELLS+1];
    logic [IDX_W-1:0]   w_dnum  [DIV_CELLS+1];
    logic [SW-1:0]      w_dsrem [DIV_CELLS+1];

    // Coordinate stages A to F.
    t_side                  r_a_side, r_b_side, r_c_side, r_d_side, r_e_side, r_f_side;
    logic [GW_W-1:0]        r_a_col;
    logic [ROW_W-1:0]       r_a_row;
    logic [CS_W+GW_W-1:0]   r_b_px;
    logic [CS_W+ROW_W-1:0]  r_b_py;
    logic signed [X_W-1:0]  r_c_x;
    logic signed [Y_W-1:0]  r_c_y;
    logic signed [XY_W-1:0] r_d_x, r_d_y, r_e_x, r_e_y;
    logic [LIM_W-1:0]       r_d_ax, r_d_ay;
    logic [SQ_W-1:0]        r_e_sqx, r_e_sqy;
    logic [D2_W-1:0]        r_f_d2;
    logic signed [CW-1:0]   r_f_cx, r_f_cy;

    logic [GW_W-1:0]        n_rem1;
    logic [GW_W-1:0]        n_col;
    t_side                  n_a_side, n_d_side, n_f_side;
    logic                   n_xbig, n_ybig;
    logic signed [XY_W-1:0] n_x, n_y;
    logic                   n_xpos, n_xzero, n_ypos, n_yzero;
    t_quad                  n_quad;
    logic [D2_W-1:0]        n_d2;
    logic signed [XY_W-1:0] n_px, n_py;

    // Square-root and CORDIC chains.
    t_side                 w_sside [SQRT_CELLS+1];
    logic [SREM_W-1:0]     w_srem  [SQRT_CELLS+1];
    logic [ROOT_W-1:0]     w_sroot [SQRT_CELLS+1];
    logic [D2_W-1:0]       w_snum  [SQRT_CELLS+1];
    logic signed [CW-1:0]  w_cx    [CORDIC_STEPS+1];
    logic signed [CW-1:0]  w_cy    [CORDIC_STEPS+1];
    logic signed [ZW-1:0]  w_cz    [CORDIC_STEPS+1];
    logic signed [ZW-1:0]  r_zdly  [ZDELAY];

    // Stage G and falloff division chain.
    t_side                 r_g_side;
    logic [ROOT_W-1:0]     r_g_q;
    t_side                 n_g_side;
    logic [ROOT_W-1:0]     n_q;
    logic signed [ZW-1:0]  n_angle;
    logic signed [ZW-1:0]  n_bear;
    logic [ZW-1:0]         n_abs;
    t_side                 w_qside [QDIV_STEPS+1];
    logic [ROOT_W-1:0]     w_qq    [QDIV_STEPS+1];
    logic [NUM_W-1:0]      w_qrem  [QDIV_STEPS+1];
    logic [WT_W-1:0]       w_qquo  [QDIV_STEPS+1];

    // Output.
    logic [WT_W-1:0] w_att_tab [2**WT_W];
    logic [WT_W-1:0] n_weight;
    logic [WT_W-1:0] n_out;
    logic            r_out_valid;
    logic [WT_W-1:0] r_out_weight;
    logic            r_out_last;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= 13'd1024;
            r_cell_size  <= 12'd205;
            r_offset_x   <= '0;
            r_offset_y   <= '0;
            r_heading    <= '0;
            r_near       <= '0;
            r_ideal      <= '0;
            r_far        <= '1;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_GRID_WIDTH: r_grid_width <= i_cfg_data[GW_W-1:0];
                CFG_CELL_SIZE:  r_cell_size  <= i_cfg_data[CS_W-1:0];
                CFG_OFFSET_X:   r_offset_x   <= $signed(i_cfg_data[OFF_W-1:0]);
                CFG_OFFSET_Y:   r_offset_y   <= $signed(i_cfg_data[OFF_W-1:0]);
                CFG_HEADING:    r_heading    <= $signed(i_cfg_data[HD_W-1:0]);
                CFG_NEAR:       r_near       <= i_cfg_data[LIM_W-1:0];
                CFG_IDEAL:      r_ideal      <= i_cfg_data[LIM_W-1:0];
                CFG_FAR:        r_far        <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The squared limits are registered; they are first needed by stage F.
    assign n_mid = MID_W'(r_near) + MID_W'(r_ideal);

    always_ff @(posedge i_clk) begin
        r_near_sq <= D2_W'(r_near * r_near);
        r_far_sq  <= D2_W'(r_far * r_far);
        r_mid_sq  <= n_mid * n_mid;
    end

    // A zero width behaves as a width of one.
    assign w_width = (r_grid_width == '0) ? GW_W'(1) : r_grid_width;

    // ------------------------------------------------------------------
    // Flow control: everything moves together unless the output holds a
    // result and the last falloff cell has another one waiting.
    // ------------------------------------------------------------------
    assign w_en            = !r_out_valid || i_m_axis_tready || !w_qside[QDIV_STEPS].valid;
    assign o_s_axis_tready = w_en;
    assign w_accept        = i_s_axis_tvalid && w_en;

    // ------------------------------------------------------------------
    // Division chain: row, column and the stride remainder.
    // ------------------------------------------------------------------
    always_comb begin
        w_dside[0]          = '0;
        w_dside[0].valid    = w_accept;
        w_dside[0].last     = i_s_axis_tlast;
        w_dside[0].kill     = 32'(i_s_axis_tdata[IDX_W-1:0]) >= 32'(MAX_CELLS);
        w_dside[0].quad     = QD_CORDIC;
    end
    assign w_drem[0]  = '0;
    assign w_dnum[0]  = i_s_axis_tdata[IDX_W-1:0];
    assign w_dsrem[0] = '0;

    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
        cpw_div_cell #(
            .STRIDE (STRIDE),
            .SW     (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_width (w_width),
            .i_side  (w_dside[g]),
            .i_rem   (w_drem[g]),
            .i_num   (w_dnum[g]),
            .i_srem  (w_dsrem[g]),
            .o_side  (w_dside[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_num   (w_dnum[g+1]),
            .o_srem  (w_dsrem[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Coordinate stages.
    // ------------------------------------------------------------------
    // Column of the next index: the remainder plus one, wrapped at the width.
    assign n_rem1 = w_drem[DIV_CELLS] + GW_W'(1);
    assign n_col  = (n_rem1 == w_width) ? '0 : n_rem1;

    always_comb begin
        n_a_side      = w_dside[DIV_CELLS];
        n_a_side.kill = w_dside[DIV_CELLS].kill || (w_dsrem[DIV_CELLS] != '0);
    end

    // A coordinate is kept only when its magnitude is below 2^23.
    assign n_xbig = !((r_c_x[X_W-1:XY_W-1] == '0) ||
                      ((r_c_x[X_W-1:XY_W-1] == '1) && (r_c_x[XY_W-2:0] != '0)));
    assign n_ybig = !((r_c_y[Y_W-1:XY_W-1] == '0) ||
                      ((r_c_y[Y_W-1:XY_W-1] == '1) && (r_c_y[XY_W-2:0] != '0)));
    assign n_x    = r_c_x[XY_W-1:0];
    assign n_y    = r_c_y[XY_W-1:0];
    assign n_xzero = (n_x == '0);
    assign n_yzero = (n_y == '0);
    assign n_xpos  = !n_x[XY_W-1] && !n_xzero;
    assign n_ypos  = !n_y[XY_W-1] && !n_yzero;

    always_comb begin
        if (n_xpos) begin
            n_quad = QD_CORDIC;
        end else if (n_xzero) begin
            n_quad = n_ypos ? QD_UP : QD_DOWN;
        end else if (n_ypos) begin
            n_quad = QD_NEG_UP;
        end else if (!n_yzero) begin
            n_quad = QD_NEG_DOWN;
        end else begin
            n_quad = QD_NEG_AXIS;
        end
    end

    always_comb begin
        n_d_side      = r_c_side;
        n_d_side.kill = r_c_side.kill || n_xbig || n_ybig;
        n_d_side.quad = n_quad;
    end

    // Distance band tests on the exact squared distance.
    assign n_d2 = D2_W'(r_e_sqx) + D2_W'(r_e_sqy);

    always_comb begin
        n_f_side          = r_e_side;
        n_f_side.kill     = r_e_side.kill || (n_d2 <= r_near_sq) || (n_d2 >= r_far_sq);
        n_f_side.nearband = (n_d2 <= r_mid_sq);
    end

    // The CORDIC always sees a vector in the right half plane.
    assign n_px = r_e_x[XY_W-1] ? -r_e_x : r_e_x;
    assign n_py = r_e_x[XY_W-1] ? -r_e_y : r_e_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_side <= '0;
            r_b_side <= '0;
            r_c_side <= '0;
            r_d_side <= '0;
            r_e_side <= '0;
            r_f_side <= '0;
        end else if (w_en) begin
            r_a_side <= n_a_side;
            r_b_side <= r_a_side;
            r_c_side <= r_b_side;
            r_d_side <= n_d_side;
            r_e_side <= r_d_side;
            r_f_side <= n_f_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_col <= n_col;
            r_a_row <= ROW_W'(w_dnum[DIV_CELLS]) + ROW_W'(1);
            r_b_px  <= r_cell_size * r_a_col;
            r_b_py  <= r_cell_size * r_a_row;
            r_c_x   <= $signed({2'b00, r_b_px}) - X_W'(r_offset_x);
            r_c_y   <= $signed({2'b00, r_b_py}) - Y_W'(r_offset_y);
            r_d_x   <= n_x;
            r_d_y   <= n_y;
            r_d_ax  <= LIM_W'(n_x[XY_W-1] ? -n_x : n_x);
            r_d_ay  <= LIM_W'(n_y[XY_W-1] ? -n_y : n_y);
            r_e_x   <= r_d_x;
            r_e_y   <= r_d_y;
            r_e_sqx <= r_d_ax * r_d_ax;
            r_e_sqy <= r_d_ay * r_d_ay;
            r_f_d2  <= n_d2;
            r_f_cx  <= CW'(n_px) <<< 8;
            r_f_cy  <= CW'(n_py) <<< 8;
        end
    end

    // ------------------------------------------------------------------
    // Square-root chain, with the CORDIC chain running alongside.
    // ------------------------------------------------------------------
    assign w_sside[0] = r_f_side;
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_snum[0]  = r_f_d2;

    for (genvar g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
        cpw_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_sside[g]),
            .i_rem   (w_srem[g]),
            .i_root  (w_sroot[g]),
            .i_num   (w_snum[g]),
            .o_side  (w_sside[g+1]),
            .o_rem   (w_srem[g+1]),
            .o_root  (w_sroot[g+1]),
            .o_num   (w_snum[g+1])
        );
    end

    assign w_cx[0] = r_f_cx;
    assign w_cy[0] = r_f_cy;
    assign w_cz[0] = '0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        cpw_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_cx  (w_cx[g]),
            .i_cy  (w_cy[g]),
            .i_z   (w_cz[g]),
            .o_cx  (w_cx[g+1]),
            .o_cy  (w_cy[g+1]),
            .o_z   (w_cz[g+1])
        );
    end

    // The angle waits here until the root catches up.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zdly[0] <= w_cz[CORDIC_STEPS];
            for (int k = 1; k < ZDELAY; k++) begin
                r_zdly[k] <= r_zdly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage G: falloff offset, saturation and bearing test.
    // ------------------------------------------------------------------
    assign n_q = w_sroot[SQRT_CELLS] - ROOT_W'(r_ideal);

    always_comb begin
        case (w_sside[SQRT_CELLS].quad)
            QD_CORDIC:   n_angle = r_zdly[ZDELAY-1];
            QD_UP:       n_angle = QUARTER_TURN;
            QD_DOWN:     n_angle = -QUARTER_TURN;
            QD_NEG_UP:   n_angle = r_zdly[ZDELAY-1] + HALF_TURN;
            QD_NEG_DOWN: n_angle = r_zdly[ZDELAY-1] - HALF_TURN;
            default:     n_angle = '0;
        endcase
    end

    assign n_bear = n_angle - ZW'(r_heading);
    assign n_abs  = n_bear[ZW-1] ? ZW'(-n_bear) : ZW'(n_bear);

    always_comb begin
        n_g_side       = w_sside[SQRT_CELLS];
        // A root at or below the ideal span, or a small offset, saturates.
        n_g_side.sat   = (w_sroot[SQRT_CELLS] <= ROOT_W'(r_ideal)) || (n_q <= SAT_Q);
        n_g_side.atten = 32'(n_abs) >= 32'(BERTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_side <= '0;
        end else if (w_en) begin
            r_g_side <= n_g_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_q <= n_q;
        end
    end

    // ------------------------------------------------------------------
    // Falloff division: one quotient bit per cell, most significant first.
    // ------------------------------------------------------------------
    assign w_qside[0] = r_g_side;
    assign w_qq[0]    = r_g_q;
    assign w_qrem[0]  = FALLOFF_NUM;
    assign w_qquo[0]  = '0;

    for (genvar g = 0; g < QDIV_STEPS; g++) begin : g_recip
        cpw_recip_cell #(
            .BIT (QDIV_STEPS - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_qside[g]),
            .i_q     (w_qq[g]),
            .i_rem   (w_qrem[g]),
            .i_quo   (w_qquo[g]),
            .o_side  (w_qside[g+1]),
            .o_q     (w_qq[g+1]),
            .o_rem   (w_qrem[g+1]),
            .o_quo   (w_qquo[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Final weight and output register.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < 2**WT_W; g++) begin : g_att
        assign w_att_tab[g] = WT_W'(g / ATTENUATOR);
    end

    always_comb begin
        if (w_qside[QDIV_STEPS].kill) begin
            n_weight = '0;
        end else if (w_qside[QDIV_STEPS].nearband) begin
            n_weight = NEAR_WEIGHT;
        end else if (w_qside[QDIV_STEPS].sat) begin
            n_weight = WEIGHT_MAX;
        end else begin
            n_weight = w_qquo[QDIV_STEPS];
        end
    end

    assign n_out = w_qside[QDIV_STEPS].atten ? w_att_tab[n_weight] : n_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= w_qside[QDIV_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            r_out_weight <= n_out;
            r_out_last   <= w_qside[QDIV_STEPS].last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_weight};
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: tb/cell_proximity_heading_weight_tb.sv
`timescale 1ns / 1ps

module cell_proximity_heading_weight_tb;
    import cpw_pkg::*;

    // Block parameters; the predictor below uses the same values.
    localparam int STRIDE_P     = 1;
    localparam int BERTH_P      = 16384;
    localparam int ATTENUATOR_P = 2;
    localparam int MAX_CELLS_P  = 1048576;

    // Settle time that wait_idle adds once all queues have drained, so that anything
    // still in flight comes out.
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        bit [19:0] idx;
        bit        fin;
    } cell_beat_t;

    typedef struct {
        bit [6:0] weight;
        bit       fin;
    } weight_beat_t;

    // Our own copy of the register file.
    typedef struct {
        bit [12:0] grid_width;
        bit [11:0] cell_size;
        bit [23:0] off_x;
        bit [23:0] off_y;
        bit [15:0] heading;
        bit [22:0] near_lim;
        bit [22:0] ideal;
        bit [22:0] far_lim;
    } map_setup_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [23:0]           i_s_axis_tdata;   // [19:0] cell_index, [23:20] zero
    logic                  i_s_axis_tlast;   // final_cell
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [7:0]            o_m_axis_tdata;   // [6:0] cell_weight, [7] zero
    logic                  o_m_axis_tlast;   // final_weight
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    map_setup_t   setup;
    cell_beat_t   cells_to_send[$];
    weight_beat_t weights_due[$];
    int           mismatches;
    int           cycles;
    bit           cell_taken;
    bit           hold_request;
    bit           hold_done;
    int           send_gap;
    int           send_calm;
    int           recv_gap;
    int           recv_calm;
    int           hold_left;

    cell_proximity_heading_weight #(
        .STRIDE    (STRIDE_P),
        .BERTH     (BERTH_P),
        .ATTENUATOR(ATTENUATOR_P),
        .MAX_CELLS (MAX_CELLS_P)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Angle of (px, py) for px > 0, from a 15 step vectoring rotation with
    // inputs scaled by 256. Arithmetic shifts round toward minus infinity.
    function automatic longint heading_angle(longint px, longint py);
        longint steps [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                               41, 20, 10, 5, 3, 1, 1};
        longint cx, cy, z, dx, dy;
        cx = px * 256;
        cy = py * 256;
        z  = 0;
        for (int i = 0; i < 15; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx += dx;
                cy -= dy;
                z  += steps[i];
            end else begin
                cx -= dx;
                cy += dy;
                z  -= steps[i];
            end
        end
        return z;
    endfunction

    // Expected weight of one cell under the current register settings.
    function automatic bit [6:0] cell_weight_predict(bit [19:0] idx);
        longint width, col, row, x, y, d2, nl, il, fl, r, b, n, w, a, brg;
        if (idx >= MAX_CELLS_P || (idx % STRIDE_P) != 0)
            return 7'd0;
        width = (setup.grid_width == 0) ? 1 : setup.grid_width;
        col = (longint'(idx) + 1) % width;
        row = 1 + longint'(idx) / width;
        x = longint'(setup.cell_size) * col - longint'($signed(setup.off_x));
        y = longint'(setup.cell_size) * row - longint'($signed(setup.off_y));
        // Coordinates this far out are beyond any far limit.
        if (x >= 8388608 || x <= -8388608 || y >= 8388608 || y <= -8388608)
            return 7'd0;
        d2 = x * x + y * y;
        nl = setup.near_lim;
        il = setup.ideal;
        fl = setup.far_lim;
        if (d2 <= nl * nl || d2 >= fl * fl)
            return 7'd0;
        if (d2 <= (nl + il) * (nl + il)) begin
            w = 100;
        end else begin
            // Integer square root, bit by bit.
            n = d2;
            r = 0;
            b = 64'sd1 <<< 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            if (r <= il) begin
                w = 127;
            end else begin
                w = 409600 / (r - il);
                if (w > 127) w = 127;
            end
        end
        // Bearing with the quadrant fix; a cell straight behind on the axis
        // gets zero and no half-turn correction.
        if (x > 0) a = heading_angle(x, y);
        else if (x == 0) a = (y > 0) ? 16384 : -16384;
        else if (y > 0) a = heading_angle(-x, -y) + 32768;
        else if (y < 0) a = heading_angle(-x, -y) - 32768;
        else a = 0;
        brg = a - longint'($signed(setup.heading));
        if (brg < 0) brg = -brg;
        if (brg >= BERTH_P) w = w / ATTENUATOR_P;
        return w[6:0];
    endfunction

    // Monitor: records accepted cell beats and checks every weight beat.
    always @(posedge i_clk) begin
        weight_beat_t exp_w;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("cell_proximity_heading_weight_tb: done, errors");
            $finish;
        end
        cell_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (cell_taken) begin
            exp_w.weight = cell_weight_predict(i_s_axis_tdata[19:0]);
            exp_w.fin    = i_s_axis_tlast;
            weights_due.insert(weights_due.size(), exp_w);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (weights_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected weight beat: weight %0d last %0b",
                             o_m_axis_tdata[6:0], o_m_axis_tlast);
            end else begin
                exp_w = weights_due.pop_front();
                if (o_m_axis_tdata[6:0] !== exp_w.weight || o_m_axis_tlast !== exp_w.fin) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("weight mismatch: expected %0d/%0b, got %0d/%0b",
                                 exp_w.weight, exp_w.fin, o_m_axis_tdata[6:0],
                                 o_m_axis_tlast);
                end
            end
        end
    end

    // Driver: offers queued cells, with random gaps between beats.
    always @(negedge i_clk) begin
        cell_beat_t c;
        int pick;
        if (i_rst_n && (!i_s_axis_tvalid || cell_taken)) begin
            if (send_gap > 0) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (cells_to_send.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else begin
                if (send_calm > 0) begin
                    send_calm--;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3) send_calm = 60;
                    else if (pick >= 95) send_gap = $urandom_range(10, 40);
                    else if (pick >= 78) send_gap = $urandom_range(1, 3);
                end
                if (send_gap > 0) begin
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    c = cells_to_send.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {4'd0, c.idx};
                    i_s_axis_tlast  <= c.fin;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    always @(negedge i_clk) begin
        int pick;
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_m_axis_tready <= 1'b0;
        end else if (recv_calm > 0) begin
            recv_calm--;
            i_m_axis_tready <= 1'b1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) recv_calm = 60;
            else if (pick >= 95) recv_gap = $urandom_range(10, 40);
            else if (pick >= 78) recv_gap = $urandom_range(1, 3);
            i_m_axis_tready <= (recv_gap == 0);
        end
    end

    task automatic wait_idle();
        while (cells_to_send.size() != 0 || weights_due.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(t_cfg_reg which, bit [23:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes every register and mirrors the values into the predictor copy.
    task automatic load_setup(map_setup_t s);
        wait_idle();
        reg_write(CFG_GRID_WIDTH, 24'(s.grid_width));
        reg_write(CFG_CELL_SIZE,  24'(s.cell_size));
        reg_write(CFG_OFFSET_X,   s.off_x);
        reg_write(CFG_OFFSET_Y,   s.off_y);
        reg_write(CFG_HEADING,    24'(s.heading));
        reg_write(CFG_NEAR,       24'(s.near_lim));
        reg_write(CFG_IDEAL,      24'(s.ideal));
        reg_write(CFG_FAR,        24'(s.far_lim));
        setup = s;
    endtask

    task automatic queue_cell(bit [19:0] idx, bit fin);
        cell_beat_t c;
        c.idx = idx;
        c.fin = fin;
        cells_to_send.insert(cells_to_send.size(), c);
    endtask

    initial begin
        map_setup_t s;
        int cols, rows, span;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_GRID_WIDTH;
        i_cfg_data      = '0;
        mismatches      = 0;
        cycles          = 0;
        cell_taken      = 1'b0;
        hold_request    = 1'b0;
        hold_done       = 1'b0;
        send_gap        = 0;
        send_calm       = 0;
        recv_gap        = 0;
        recv_calm       = 0;
        hold_left       = 0;
        setup = '{grid_width: 13'd1024, cell_size: 12'd205, off_x: 24'd0, off_y: 24'd0,
                  heading: 16'd0, near_lim: 23'd0, ideal: 23'd0, far_lim: 23'h7FFFFF};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults and index extremes, up to the largest 20-bit index.
        queue_cell(20'd0, 1'b0);
        queue_cell(20'd1, 1'b0);
        queue_cell(20'd1023, 1'b0);
        queue_cell(20'd40000, 1'b0);
        queue_cell(20'hFFFFF, 1'b1);

        // A tiny map around the car: every quadrant, the point on the car,
        // the axis behind it, and a near band of nonzero width.
        s = '{grid_width: 13'd4, cell_size: 12'd1, off_x: 24'd2, off_y: 24'd3,
              heading: 16'd0, near_lim: 23'd0, ideal: 23'd0, far_lim: 23'd100};
        load_setup(s);
        for (int i = 0; i < 16; i++) queue_cell(20'(i), i == 15);
        s.near_lim = 23'd1;
        s.ideal    = 23'd1;
        s.heading  = 16'h8000;
        load_setup(s);
        for (int i = 0; i < 8; i++) queue_cell(20'(i), i == 7);

        // Zero grid width acts as one; empty band where far does not exceed near.
        s = '{grid_width: 13'd0, cell_size: 12'd4095, off_x: 24'd0, off_y: 24'd40000,
              heading: 16'h7FFF, near_lim: 23'd5000, ideal: 23'd0, far_lim: 23'd5000};
        load_setup(s);
        queue_cell(20'd5, 1'b0);
        queue_cell(20'd9, 1'b1);

        // Register extremes and the widest field values.
        s = '{grid_width: 13'h1FFF, cell_size: 12'hFFF, off_x: 24'h800000,
              off_y: 24'h7FFFFF, heading: 16'h8000, near_lim: 23'd0,
              ideal: 23'h7FFFFF, far_lim: 23'h7FFFFF};
        load_setup(s);
        queue_cell(20'd0, 1'b0);
        queue_cell(20'd8190, 1'b1);

        // Random maps: mostly cells within a few hundred thousand units of the
        // car so every weight region is reached, some cells anywhere at all.
        for (int ph = 0; ph < 7; ph++) begin
            cols = $urandom_range(1, 64);
            rows = $urandom_range(1, 80);
            s.grid_width = 13'(cols);
            s.cell_size  = 12'($urandom_range(100, 4095));
            s.off_x      = 24'(s.cell_size * $urandom_range(0, cols) + $urandom_range(0, 400)
                               - 200);
            s.off_y      = 24'(s.cell_size * $urandom_range(0, rows) + $urandom_range(0, 400)
                               - 200);
            s.heading    = 16'($urandom);
            s.near_lim   = 23'($urandom_range(0, 20000));
            s.ideal      = 23'($urandom_range(0, 20000));
            span         = $urandom_range(0, 3);
            s.far_lim    = (span == 0) ? 23'h7FFFFF :
                           23'(s.near_lim + $urandom_range(0, 400000));
            load_setup(s);
            for (int i = 0; i < 130; i++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_cell(20'($urandom), $urandom_range(0, 1));
                else
                    queue_cell(20'($urandom_range(0, cols * (rows + 1))), i == 129);
            end
            if (ph == 3) hold_request = 1'b1;
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("cell_proximity_heading_weight_tb: done, clean");
        end else begin
            $display("cell_proximity_heading_weight_tb: done, errors");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/cpw_pkg.sv
hdl/cpw_div_cell.sv
hdl/cpw_sqrt_cell.sv
hdl/cpw_cordic_cell.sv
hdl/cpw_recip_cell.sv
hdl/cell_proximity_heading_weight.sv
tb/cell_proximity_heading_weight_tb.sv
